/* sv/vna_pkg.sv */
// vna_pkg: shared types and codes for the vertex normal accumulator.
// No dependencies.
`timescale 1ns / 1ps
package vna_pkg;
    localparam int COORD_BITS = 16;
    localparam int SUM_BITS   = 48;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_TRI   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_BAD   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_CMD   = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RDA, S_RDB, S_RDC, S_WAITC,
        S_DIFF,
        S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_MUL5, S_MULW,
        S_SRD, S_SWAIT, S_SADD, S_SWR,
        S_RRD, S_RWAIT,
        S_OUT
    } t_state;
endpackage

/* sv/vertex_normal_accumulator.sv */
// Top level: vertex_normal_accumulator. Uses vna_pkg and vna_ram.
// Position and normal-sum tables in single-port RAMs, one shared multiplier.
// A triangle takes 3 position reads, 6 products through one multiplier and 3
// read-modify-write passes on the sums. One item at a time; o_s_tready is high
// only in idle, so a new item is taken only once the last one has reached the
// output register. A finished result waits in the output register; the sequencer
// holds in its last state until that register is free.
// Reset (sync, active low) clears control only; tables are undefined until written.
`timescale 1ns / 1ps
module vertex_normal_accumulator #(
    parameter int MAX_VERTICES = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // vertex_a[11:0], vertex_b[23:12], vertex_c[35:24], coord_x[51:36],
    // coord_y[67:52], coord_z[83:68], zero pad [87:84]
    input  logic [87:0]  i_s_tdata,
    // command[1:0]
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // status[1:0], sum_x[49:2], sum_y[97:50], sum_z[145:98], zero pad [151:146]
    output logic [151:0] o_m_tdata
);
    import vna_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int CW = PW + 1;
    localparam int SW = SUM_BITS + 1;
    localparam logic signed [SUM_BITS-1:0] SMAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SMIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    t_state r_state, n_state;
    logic [1:0]  r_cmd;
    logic [11:0] r_ia, r_ib, r_ic;
    logic [3*COORD_BITS-1:0] r_wpos;
    logic signed [COORD_BITS-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic signed [DW-1:0] r_f [3];
    logic signed [DW-1:0] r_g [3];
    logic signed [PW-1:0] r_prod;
    logic signed [CW-1:0] r_n [3];
    logic [1:0]  r_k;
    logic [1:0]  r_status;
    logic signed [SUM_BITS-1:0] r_sum [3];
    logic [3*SUM_BITS+1:0] r_odata;
    logic r_ovalid;

    logic                     pos_we, sum_we;
    logic [AW-1:0]            addr;
    logic [3*COORD_BITS-1:0]  pos_rd;
    logic [3*SUM_BITS-1:0]    sum_rd, sum_wd;
    logic signed [COORD_BITS-1:0] px, py, pz;
    logic signed [SUM_BITS-1:0]   sadd [3];
    logic accept, out_free, range_ok;
    logic signed [DW-1:0] mul_a, mul_b;
    logic [11:0] cur_idx;

    assign accept   = i_s_tvalid && o_s_tready;
    assign out_free = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign px = pos_rd[COORD_BITS-1:0];
    assign py = pos_rd[2*COORD_BITS-1:COORD_BITS];
    assign pz = pos_rd[3*COORD_BITS-1:2*COORD_BITS];

    always_comb begin
        range_ok = 32'(r_ia) < MAX_VERTICES;
        if (t_cmd'(r_cmd) == CMD_TRI) begin
            range_ok = range_ok && (32'(r_ib) < MAX_VERTICES)
                       && (32'(r_ic) < MAX_VERTICES);
        end
    end

    always_comb begin
        case (r_k)
            2'd0:    cur_idx = r_ia;
            2'd1:    cur_idx = r_ib;
            default: cur_idx = r_ic;
        endcase
    end

    vna_ram #(.WIDTH(3*COORD_BITS), .DEPTH(MAX_VERTICES)) u_pos (
        .i_clk(i_clk), .i_we(pos_we), .i_addr(addr),
        .i_wdata(r_wpos), .o_rdata(pos_rd));
    vna_ram #(.WIDTH(3*SUM_BITS), .DEPTH(MAX_VERTICES)) u_sum (
        .i_clk(i_clk), .i_we(sum_we), .i_addr(addr),
        .i_wdata(sum_wd), .o_rdata(sum_rd));

    // saturating add of the cross component to each sum lane
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            logic signed [SW-1:0] t;
            t = SW'(signed'(sum_rd[j*SUM_BITS +: SUM_BITS])) + SW'(r_n[j]);
            if (t > SW'(SMAX))      sadd[j] = SMAX;
            else if (t < SW'(SMIN)) sadd[j] = SMIN;
            else                    sadd[j] = SUM_BITS'(t);
        end
    end

    always_comb begin
        pos_we = 1'b0;
        sum_we = 1'b0;
        addr   = AW'(r_ia);
        sum_wd = '0;
        unique case (r_state)
            S_RDA:  begin
                addr = AW'(r_ia);
                if (t_cmd'(r_cmd) == CMD_WRITE && range_ok) begin
                    pos_we = 1'b1;
                    sum_we = 1'b1;
                end
            end
            S_RDB:  addr = AW'(r_ib);
            // hold the third position on the read port through the difference step
            S_RDC, S_WAITC: addr = AW'(r_ic);
            S_SRD, S_SWAIT, S_SADD: addr = AW'(cur_idx);
            S_SWR:  begin
                addr   = AW'(cur_idx);
                sum_we = 1'b1;
                sum_wd = {sadd[2], sadd[1], sadd[0]};
            end
            default: addr = AW'(r_ia);
        endcase
    end

    // shared multiplier operand select: fy*gz, fz*gy, fz*gx, fx*gz, fx*gy, fy*gx
    always_comb begin
        unique case (r_state)
            S_MUL0:  begin mul_a = r_f[1]; mul_b = r_g[2]; end
            S_MUL1:  begin mul_a = r_f[2]; mul_b = r_g[1]; end
            S_MUL2:  begin mul_a = r_f[2]; mul_b = r_g[0]; end
            S_MUL3:  begin mul_a = r_f[0]; mul_b = r_g[2]; end
            S_MUL4:  begin mul_a = r_f[0]; mul_b = r_g[1]; end
            default: begin mul_a = r_f[1]; mul_b = r_g[0]; end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_RDA;
            S_RDA:   begin
                if (!range_ok || t_cmd'(r_cmd) == CMD_BAD || t_cmd'(r_cmd) == CMD_WRITE)
                    n_state = S_OUT;
                else if (t_cmd'(r_cmd) == CMD_READ) n_state = S_RWAIT;
                else n_state = S_RDB;
            end
            S_RDB:   n_state = S_RDC;
            S_RDC:   n_state = S_WAITC;
            S_WAITC: n_state = S_DIFF;
            S_DIFF:  n_state = S_MUL0;
            S_MUL0:  n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_MUL3;
            S_MUL3:  n_state = S_MUL4;
            S_MUL4:  n_state = S_MUL5;
            S_MUL5:  n_state = S_MULW;
            S_MULW:  n_state = S_SRD;
            S_SRD:   n_state = S_SWAIT;
            S_SWAIT: n_state = S_SADD;
            S_SADD:  n_state = S_SWR;
            S_SWR:   n_state = (r_k == 2'd2) ? S_OUT : S_SRD;
            S_RRD:   n_state = S_RWAIT;
            S_RWAIT: n_state = S_OUT;
            // hold until the output register is free
            S_OUT:   n_state = out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) r_ovalid <= 1'b1;
            else if (i_m_tready)              r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            S_IDLE: if (accept) begin
                r_cmd <= i_s_tuser;
                r_ia  <= i_s_tdata[11:0];
                r_ib  <= i_s_tdata[23:12];
                r_ic  <= i_s_tdata[35:24];
                r_wpos <= {i_s_tdata[68 +: COORD_BITS], i_s_tdata[52 +: COORD_BITS],
                           i_s_tdata[36 +: COORD_BITS]};
                r_k   <= 2'd0;
                r_sum[0] <= '0; r_sum[1] <= '0; r_sum[2] <= '0;
            end
            S_RDA: begin
                if (t_cmd'(r_cmd) == CMD_BAD)  r_status <= ST_CMD;
                else if (!range_ok)            r_status <= ST_RANGE;
                else                           r_status <= ST_OK;
            end
            S_RDB:  begin r_ax <= px; r_ay <= py; r_az <= pz; end
            S_RDC:  begin r_bx <= px; r_by <= py; r_bz <= pz; end
            S_DIFF: begin
                r_f[0] <= DW'(r_ax) - DW'(r_bx);
                r_f[1] <= DW'(r_ay) - DW'(r_by);
                r_f[2] <= DW'(r_az) - DW'(r_bz);
                r_g[0] <= DW'(r_ax) - DW'(px);
                r_g[1] <= DW'(r_ay) - DW'(py);
                r_g[2] <= DW'(r_az) - DW'(pz);
            end
            S_MUL1: r_n[0] <= CW'(r_prod);
            S_MUL2: r_n[0] <= r_n[0] - CW'(r_prod);
            S_MUL3: r_n[1] <= CW'(r_prod);
            S_MUL4: r_n[1] <= r_n[1] - CW'(r_prod);
            S_MUL5: r_n[2] <= CW'(r_prod);
            S_MULW: r_n[2] <= r_n[2] - CW'(r_prod);
            S_SWR:  r_k <= r_k + 2'd1;
            S_RWAIT: begin
                r_sum[0] <= sum_rd[SUM_BITS-1:0];
                r_sum[1] <= sum_rd[2*SUM_BITS-1:SUM_BITS];
                r_sum[2] <= sum_rd[3*SUM_BITS-1:2*SUM_BITS];
            end
            S_OUT: if (out_free) r_odata <= {r_sum[2], r_sum[1], r_sum[0], r_status};
            default: ;
        endcase
    end

    // RDA issues the read for a read command; RRD is unused path, kept idle
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {6'b0, r_odata};

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_s_tready) else $error("ready while busy");
    a_out_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> o_m_tvalid) else $error("result lost");
    a_sum_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sum_we |-> (r_state == S_SWR || r_state == S_RDA)) else $error("stray write");
endmodule

/* sv/vna_ram.sv */
// vna_ram: generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module vna_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* tb/tb_vertex_normal_accumulator.sv */
// Testbench for vertex_normal_accumulator: random and directed commands with a
// scoreboard that predicts status and normal sums. Depends on vna_pkg and the RTL.
`timescale 1ns / 1ps
module tb_vertex_normal_accumulator;
    import vna_pkg::*;

    localparam int NV = 4096;
    localparam logic signed [47:0] SUM_HI = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SUM_LO = 48'sh8000_0000_0000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [87:0] data;
    } t_item;

    // lowest bits last: status sits at [1:0] as on the result bus
    typedef struct packed {
        logic signed [47:0] sz;
        logic signed [47:0] sy;
        logic signed [47:0] sx;
        logic [1:0]         status;
    } t_sum_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [87:0]  i_s_tdata = '0;
    logic [1:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [151:0] o_m_tdata;

    vertex_normal_accumulator dut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    logic signed [15:0] pos_x [NV];
    logic signed [15:0] pos_y [NV];
    logic signed [15:0] pos_z [NV];
    logic signed [47:0] acc_x [NV];
    logic signed [47:0] acc_y [NV];
    logic signed [47:0] acc_z [NV];
    bit                 written [NV];

    t_item       pending_items [$];
    t_sum_result expected_sums [$];
    int          mismatches = 0;
    int          send_idle = 0;
    int          recv_stall = 0;
    bit          recv_hold = 1'b0;
    bit          done_stim = 1'b0;

    function automatic logic signed [47:0] sat_sum(logic signed [47:0] s,
                                                    logic signed [47:0] n);
        logic signed [48:0] t;
        t = s + n;
        if (t > SUM_HI) return SUM_HI;
        if (t < SUM_LO) return SUM_LO;
        return t[47:0];
    endfunction

    function automatic t_sum_result predict_normals(t_item it);
        t_sum_result r;
        logic [11:0] va, vb, vc;
        logic signed [16:0] fx, fy, fz, gx, gy, gz;
        logic signed [47:0] nx, ny, nz;
        logic [11:0] vs [3];
        r = '0;
        va = it.data[11:0];
        vb = it.data[23:12];
        vc = it.data[35:24];
        case (t_cmd'(it.cmd))
            CMD_WRITE: begin
                pos_x[va] = it.data[51:36];
                pos_y[va] = it.data[67:52];
                pos_z[va] = it.data[83:68];
                acc_x[va] = '0;
                acc_y[va] = '0;
                acc_z[va] = '0;
                written[va] = 1'b1;
            end
            CMD_TRI: begin
                fx = pos_x[va] - pos_x[vb];
                fy = pos_y[va] - pos_y[vb];
                fz = pos_z[va] - pos_z[vb];
                gx = pos_x[va] - pos_x[vc];
                gy = pos_y[va] - pos_y[vc];
                gz = pos_z[va] - pos_z[vc];
                nx = 48'(fy * gz) - 48'(fz * gy);
                ny = 48'(fz * gx) - 48'(fx * gz);
                nz = 48'(fx * gy) - 48'(fy * gx);
                vs = '{va, vb, vc};
                foreach (vs[k]) begin
                    acc_x[vs[k]] = sat_sum(acc_x[vs[k]], nx);
                    acc_y[vs[k]] = sat_sum(acc_y[vs[k]], ny);
                    acc_z[vs[k]] = sat_sum(acc_z[vs[k]], nz);
                end
            end
            CMD_READ: begin
                r.sx = acc_x[va];
                r.sy = acc_y[va];
                r.sz = acc_z[va];
            end
            default: r.status = ST_CMD;
        endcase
        return r;
    endfunction

    function automatic t_item make_item(t_cmd c, int a, int b, int cc,
                                        int x, int y, int z);
        t_item it;
        it.cmd = c;
        it.data = {4'b0, 16'(z), 16'(y), 16'(x), 12'(cc), 12'(b), 12'(a)};
        return it;
    endfunction

    function automatic void add_pending(t_item it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF;
            1: return 32'h8000;
            2: return int'($urandom_range(0, 255)) - 128;
            default: return int'($urandom);
        endcase
    endfunction

    // pick a written vertex, mostly from a small working set
    function automatic int pick_written();
        int v;
        do v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NV - 1)
                                           : $urandom_range(0, 31);
        while (!written[v]);
        return v;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            t_item it;
            // drop the item accepted at this edge
            if (i_s_tvalid) void'(pending_items.pop_front());
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                it = pending_items[0];
                i_s_tvalid <= 1'b1;
                i_s_tdata <= it.data;
                i_s_tuser <= it.cmd;
                expected_sums.insert(expected_sums.size(), predict_normals(it));
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                t_sum_result got, want;
                got = o_m_tdata[145:0];
                if (expected_sums.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    want = expected_sums.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected st=%0d %0d %0d %0d got st=%0d %0d %0d %0d",
                                     want.status, want.sx, want.sy, want.sz,
                                     got.status, got.sx, got.sy, got.sz);
                    end
                end
            end
            i_m_tready <= !recv_hold && ($urandom_range(0, 99) >= recv_stall);
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || expected_sums.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic queue_random(int n);
        int c, a, b, cc;
        for (int i = 0; i < n; i++) begin
            c = $urandom_range(0, 99);
            if (c < 30) begin
                a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NV - 1)
                                                : $urandom_range(0, 31);
                add_pending(make_item(CMD_WRITE, a, $urandom, $urandom,
                                      rand_coord(), rand_coord(), rand_coord()));
                written[a] = 1'b1;
            end else if (c < 70) begin
                a = pick_written();
                b = ($urandom_range(0, 15) == 0) ? a : pick_written();
                cc = pick_written();
                add_pending(make_item(CMD_TRI, a, b, cc, $urandom,
                                      $urandom, $urandom));
            end else if (c < 95) begin
                add_pending(make_item(CMD_READ, pick_written(), $urandom,
                                      $urandom, $urandom, $urandom, $urandom));
            end else begin
                add_pending(make_item(CMD_BAD, $urandom, $urandom, $urandom,
                                      $urandom, $urandom, $urandom));
            end
        end
    endtask

    initial begin
        int phase_idle [4];
        int phase_stall [4];
        phase_idle = '{0, 60, 0, 31};
        phase_stall = '{0, 0, 60, 31};
        foreach (written[i]) written[i] = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, repeated index, every command
        written[0] = 1; written[1] = 1; written[2] = 1; written[4095] = 1;
        add_pending(make_item(CMD_WRITE, 0, 0, 0, 32'h7FFF, 32'h8000, 32'h7FFF));
        add_pending(make_item(CMD_WRITE, 1, 0, 0, 32'h8000, 32'h7FFF, 32'h8000));
        add_pending(make_item(CMD_WRITE, 2, 0, 0, 32'h8000, 32'h8000, 32'h7FFF));
        add_pending(make_item(CMD_WRITE, 4095, 4095, 4095, 32'hFFFF, 32'hFFFF, 32'hFFFF));
        add_pending(make_item(CMD_TRI, 0, 0, 1, 0, 0, 0));
        add_pending(make_item(CMD_TRI, 4095, 4095, 4095, 0, 0, 0));
        for (int i = 0; i < 12; i++) add_pending(make_item(CMD_TRI, 0, 1, 2, 0, 0, 0));
        for (int i = 0; i < 12; i++) add_pending(make_item(CMD_TRI, 0, 2, 1, 0, 0, 0));
        add_pending(make_item(CMD_READ, 0, 0, 0, 0, 0, 0));
        add_pending(make_item(CMD_READ, 1, 0, 0, 0, 0, 0));
        add_pending(make_item(CMD_READ, 4095, 0, 0, 0, 0, 0));
        add_pending(make_item(CMD_BAD, 4095, 4095, 4095, 32'hFFFF, 32'hFFFF, 32'hFFFF));
        wait_drained();

        foreach (phase_idle[p]) begin
            send_idle = phase_idle[p];
            recv_stall = phase_stall[p];
            queue_random(400);
            if (p == 1) begin
                // long receiver hold-off while items keep coming
                recv_hold = 1'b1;
                repeat (300) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            wait_drained();
        end
        done_stim = 1'b1;
    end

    always @(posedge i_clk) begin
        if (done_stim) begin
            if (mismatches == 0 && expected_sums.size() == 0)
                $display("Regression PASS");
            else
                $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
